// ===== sv/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while the active-low reset is asserted
`define BLRT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: property violated");

// implication form built on the one above
`define BLRT_IMPLY(lbl, clk, rst_n, ante, cons) \
    `BLRT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ===== sv/blrt_pkg.sv =====
// package: sizes and shared types of the longest-run tracker
package blrt_pkg;

    localparam int ROWS   = 64;
    localparam int COLS   = 64;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int CFG_W  = 7;
    localparam int LEN_W  = 7;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(ROWS + 1);

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_TOGGLE = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             value;
        logic             in_range;
    } t_item;

    typedef struct packed {
        logic [COLS-1:0]  word;
        logic [LEN_W-1:0] best;
    } t_row_entry;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic             in_range;
        logic [LEN_W-1:0] old_best;
        logic [LEN_W-1:0] new_best;
    } t_cnt_upd;

endpackage

// ===== sv/blrt_row_store.sv =====
// row memory: grid word and best run per row, with per-row valid bits
module blrt_row_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [blrt_pkg::ROW_AW-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [blrt_pkg::ROW_AW-1:0] i_wr_addr,
    input  blrt_pkg::t_row_entry     i_wr_data,
    output blrt_pkg::t_row_entry     o_rd_data,
    output logic                     o_rd_vld
);
    import blrt_pkg::*;

    t_row_entry      r_mem [ROWS];
    t_row_entry      r_rd_data;
    logic [ROWS-1:0] r_vld;
    logic            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // valid bits: a row never written reads as not valid, which the update takes as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule

// ===== sv/blrt_run_measure.sv =====
// longest run of ones in a masked row word, by doubling masks and a greedy search
module blrt_run_measure (
    input  logic [blrt_pkg::COLS-1:0]  i_word,
    output logic [blrt_pkg::LEN_W-1:0] o_len
);
    import blrt_pkg::*;

    localparam int LVLS = $clog2(COLS + 1);

    logic [COLS-1:0] w_run [LVLS];
    logic [COLS-1:0] w_end;
    logic [COLS-1:0] w_hit;
    logic [LEN_W-1:0] w_len;

    // w_run[k][i]: bits i .. i+2^k-1 are all ones
    always_comb begin
        w_run[0] = i_word;
        for (int k = 1; k < LVLS; k++) begin
            w_run[k] = w_run[k-1] & (w_run[k-1] >> (1 << (k - 1)));
        end
    end

    // w_end marks positions just past a run of the length found so far
    always_comb begin
        w_end = '1;
        w_len = '0;
        w_hit = '0;
        for (int k = LVLS - 1; k >= 0; k--) begin
            w_hit = w_end & w_run[k];
            if (|w_hit) begin
                w_len = w_len | LEN_W'(1 << k);
                w_end = w_hit << (1 << k);
            end
        end
    end

    assign o_len = w_len;

endmodule

// ===== sv/blrt_row_update.sv =====
// row read-modify-write: forward, apply item, remeasure, write back
module blrt_row_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blrt_pkg::t_item             i_item,
    input  blrt_pkg::t_row_entry        i_rd_data,
    input  logic                        i_rd_vld,
    input  logic [blrt_pkg::CFG_W-1:0]  i_cols,
    output logic                        o_wr_en,
    output logic [blrt_pkg::ROW_AW-1:0] o_wr_addr,
    output blrt_pkg::t_row_entry        o_wr_data,
    output blrt_pkg::t_cnt_upd          o_upd
);
    import blrt_pkg::*;

    logic                r_fw_vld;
    logic [ROW_AW-1:0]   r_fw_row;
    t_row_entry          r_fw_data;
    t_cnt_upd            r_upd;
    t_cnt_upd            n_upd;

    t_row_entry          w_cur;
    logic [COLS-1:0]     w_bit;
    logic [COLS-1:0]     w_word;
    logic [COLS-1:0]     w_mask;
    logic [LEN_W-1:0]    w_best;
    logic                w_wr;
    logic [ROW_AW-1:0]   w_addr;

    assign w_addr = ROW_AW'(i_item.row);

    // the memory read misses the write made at the same edge
    always_comb begin
        if (r_fw_vld && (r_fw_row == w_addr)) begin
            w_cur = r_fw_data;
        end else if (i_rd_vld) begin
            w_cur = i_rd_data;
        end else begin
            w_cur = '0;
        end
    end

    always_comb begin
        w_bit = COLS'(1) << i_item.col;
        case (i_item.kind)
            KIND_LOAD: begin
                w_word = i_item.value ? (w_cur.word | w_bit) : (w_cur.word & ~w_bit);
            end
            KIND_TOGGLE: begin
                w_word = w_cur.word ^ w_bit;
            end
            default: begin
                w_word = w_cur.word;
            end
        endcase
    end

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            w_mask[c] = (LEN_W'(c) < i_cols);
        end
    end

    blrt_run_measure u_measure (
        .i_word (w_word & w_mask),
        .o_len  (w_best)
    );

    assign w_wr = i_item.valid && i_item.in_range;

    always_comb begin
        n_upd.valid    = i_item.valid;
        n_upd.kind     = i_item.kind;
        n_upd.in_range = i_item.in_range;
        n_upd.old_best = w_cur.best;
        n_upd.new_best = w_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld    <= 1'b0;
            r_upd.valid <= 1'b0;
        end else begin
            r_fw_vld    <= w_wr;
            r_upd.valid <= n_upd.valid;
        end
        r_fw_row       <= w_addr;
        r_fw_data.word <= w_word;
        r_fw_data.best <= w_best;
        r_upd.kind     <= n_upd.kind;
        r_upd.in_range <= n_upd.in_range;
        r_upd.old_best <= n_upd.old_best;
        r_upd.new_best <= n_upd.new_best;
    end

    assign o_wr_en        = w_wr;
    assign o_wr_addr      = w_addr;
    assign o_wr_data.word = w_word;
    assign o_wr_data.best = w_best;
    assign o_upd          = r_upd;

endmodule

// ===== sv/blrt_len_counts.sv =====
// per-length row counters and the grid maximum for toggle reports
module blrt_len_counts (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blrt_pkg::t_cnt_upd          i_upd,
    output logic                        o_strobe,
    output logic [blrt_pkg::LEN_W-1:0]  o_longest_run
);
    import blrt_pkg::*;

    logic [CNT_W-1:0] r_cnt [COLS];
    logic [CNT_W-1:0] n_cnt [COLS];
    logic             r_rep_pend;
    logic             r_strobe;
    logic [LEN_W-1:0] r_longest;
    logic [LEN_W-1:0] w_max;
    logic             w_en;

    assign w_en = i_upd.valid && i_upd.in_range;

    // each counter watches for its own length on the old and new best
    always_comb begin
        for (int l = 0; l < COLS; l++) begin
            n_cnt[l] = r_cnt[l];
            if (w_en && (i_upd.old_best == LEN_W'(l + 1)) && (r_cnt[l] != '0)) begin
                n_cnt[l] = n_cnt[l] - CNT_W'(1);
            end
            if (w_en && (i_upd.new_best == LEN_W'(l + 1))) begin
                n_cnt[l] = n_cnt[l] + CNT_W'(1);
            end
        end
    end

    // highest length with a nonzero count
    always_comb begin
        w_max = '0;
        for (int l = 0; l < COLS; l++) begin
            if (r_cnt[l] != '0) begin
                w_max = LEN_W'(l + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < COLS; l++) begin
                r_cnt[l] <= '0;
            end
            r_rep_pend <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            for (int l = 0; l < COLS; l++) begin
                r_cnt[l] <= n_cnt[l];
            end
            r_rep_pend <= i_upd.valid && (i_upd.kind == KIND_TOGGLE);
            r_strobe   <= r_rep_pend;
        end
        r_longest <= w_max;
    end

    assign o_strobe      = r_strobe;
    assign o_longest_run = r_longest;

endmodule

// ===== sv/bit_grid_longest_run_tracker_top.sv =====
// top level: longest run of ones tracker over a bit grid
// result: a toggle's result is on o_longest_run with o_strobe after r_s1, r_upd, r_rep_pend and r_strobe
// throughput: one item per cycle; busy stays low, the row read-modify-write is closed
//   by a one-deep write forward around the registered read of the row memory
// reset: synchronous, active low; row valid bits, length counters and pipeline valids are
//   cleared and the size registers set to 64 at once, no clearing pass
module bit_grid_longest_run_tracker_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_kind,
    input  logic [blrt_pkg::ROW_W-1:0]  i_row,
    input  logic [blrt_pkg::COL_W-1:0]  i_col,
    input  logic                        i_value,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [blrt_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                        o_strobe,
    output logic [blrt_pkg::LEN_W-1:0]  o_longest_run
);
    import blrt_pkg::*;

    // configuration register indexes
    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;

    // stage 1 item register, filled at the accepting edge
    t_item            r_s1;
    t_item            n_s1;
    logic             w_accept;

    t_row_entry       w_rd_data;
    logic             w_rd_vld;
    logic             w_wr_en;
    logic [ROW_AW-1:0] w_wr_addr;
    t_row_entry       w_wr_data;
    t_cnt_upd         w_upd;

    // never stalls: every start is taken
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // size registers; register values above the grid size clamp via the fixed bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(64);
            r_cols <= CFG_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS_IN_USE: r_rows <= i_cfg_data;
                REG_COLS_IN_USE: r_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // out-of-range items are carried along but change no state
    always_comb begin
        n_s1.valid    = w_accept;
        n_s1.kind     = i_kind;
        n_s1.row      = i_row;
        n_s1.col      = i_col;
        n_s1.value    = i_value;
        n_s1.in_range = ({1'b0, i_row} < r_rows) && (32'(i_row) < ROWS)
                     && ({1'b0, i_col} < r_cols) && (32'(i_col) < COLS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.kind     <= n_s1.kind;
        r_s1.row      <= n_s1.row;
        r_s1.col      <= n_s1.col;
        r_s1.value    <= n_s1.value;
        r_s1.in_range <= n_s1.in_range;
    end

    // row word and best run are read at the accepting edge
    blrt_row_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (ROW_AW'(i_row)),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data),
        .o_rd_vld  (w_rd_vld)
    );

    // stage 1: modify the row, remeasure, write back
    blrt_row_update u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (r_s1),
        .i_rd_data (w_rd_data),
        .i_rd_vld  (w_rd_vld),
        .i_cols    (r_cols),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_upd     (w_upd)
    );

    // stage 2 moves the row between length counts, stage 3 reports the maximum
    blrt_len_counts u_counts (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (w_upd),
        .o_strobe      (o_strobe),
        .o_longest_run (o_longest_run)
    );

endmodule

// ===== sv/blrt_checker.sv =====
// port-level checks for the tracker top, bound to it below
`include "assert_macros.svh"

module blrt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_kind,
    input logic                        o_strobe,
    input logic [blrt_pkg::LEN_W-1:0]  o_longest_run
);
    import blrt_pkg::*;

    `BLRT_IMPLY(a_toggle_reports, i_clk, i_rst_n, start && !busy && i_kind, ##4 o_strobe)
    `BLRT_IMPLY(a_load_silent, i_clk, i_rst_n, start && !busy && !i_kind, ##4 !o_strobe)
    `BLRT_IMPLY(a_run_bound, i_clk, i_rst_n, o_strobe, o_longest_run <= LEN_W'(COLS))
    `BLRT_IMPLY(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_strobe)

endmodule

bind bit_grid_longest_run_tracker_top blrt_checker u_blrt_checker (.*);

// ===== bench/testbench.sv =====
// testbench for the bit grid longest run tracker: scoreboard class, stimulus tasks, top module
`timescale 1ns / 1ps

module testbench;
    import blrt_pkg::*;

    // register indexes of the size port
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // LATENCY is the assumed report delay of a toggle; SETTLE adds spare margin on top
    localparam int LATENCY = 3;
    localparam int SETTLE  = LATENCY + 4;

    // tracks the grid, per-row best runs and per-length row counts,
    // and holds the longest runs that pending toggles must report
    class grid_run_board;
        logic [COLS-1:0]  cells [ROWS];
        int unsigned      best [ROWS];
        int unsigned      len_count [COLS];
        logic [CFG_W-1:0] rows_reg;
        logic [CFG_W-1:0] cols_reg;
        logic [LEN_W-1:0] expected_runs [$];
        int               errors;
        int               checked;
        int               loads;
        int               toggles;

        function new();
            foreach (cells[r]) begin
                cells[r] = '0;
                best[r]  = 0;
            end
            foreach (len_count[l]) len_count[l] = 0;
            rows_reg = 7'd64;
            cols_reg = 7'd64;
            errors   = 0;
            checked  = 0;
            loads    = 0;
            toggles  = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == REG_ROWS) rows_reg = data;
            else cols_reg = data;
        endfunction

        // longest stretch of ones among the low ncols bits
        function int unsigned run_of(logic [COLS-1:0] w, int unsigned ncols);
            int unsigned top;
            int unsigned cur;
            top = 0;
            cur = 0;
            for (int unsigned c = 0; c < ncols; c++) begin
                if (w[c]) begin
                    cur++;
                    if (cur > top) top = cur;
                end else begin
                    cur = 0;
                end
            end
            return top;
        endfunction

        function int unsigned top_length();
            for (int l = COLS; l >= 1; l--) begin
                if (len_count[l-1] != 0) return l;
            end
            return 0;
        endfunction

        function void note_item(logic kind, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                logic v);
            int unsigned eff_rows;
            int unsigned eff_cols;
            int unsigned was;
            int unsigned now;
            eff_rows = (rows_reg > ROWS) ? ROWS : rows_reg;
            eff_cols = (cols_reg > COLS) ? COLS : cols_reg;
            if (r < eff_rows && c < eff_cols) begin
                if (kind == KIND_LOAD) cells[r][c] = v;
                else cells[r][c] = ~cells[r][c];
                was = best[r];
                now = run_of(cells[r], eff_cols);
                if (was >= 1 && was <= COLS && len_count[was-1] != 0) len_count[was-1]--;
                if (now >= 1) len_count[now-1]++;
                best[r] = now;
            end
            if (kind == KIND_TOGGLE) begin
                expected_runs.push_back(LEN_W'(top_length()));
                toggles++;
            end else begin
                loads++;
            end
        endfunction

        function void check_run(logic [LEN_W-1:0] got);
            logic [LEN_W-1:0] want;
            checked++;
            if (expected_runs.size() == 0) begin
                $display("%0t: result with no toggle waiting, actual longest_run %0d",
                         $time, got);
                errors++;
            end else begin
                want = expected_runs.pop_front();
                if (got !== want) begin
                    $display("%0t: longest_run mismatch, expected %0d actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    logic              i_kind     = KIND_LOAD;
    logic [ROW_W-1:0]  i_row      = '0;
    logic [COL_W-1:0]  i_col      = '0;
    logic              i_value    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic              i_cfg_idx  = REG_ROWS;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              o_strobe;
    logic [LEN_W-1:0]  o_longest_run;

    grid_run_board board;
    int            idle_odds;     // 0 means the sender never pauses
    int            settings_seen;

    bit_grid_longest_run_tracker_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_longest_run (o_longest_run)
    );

    always #5 i_clk = ~i_clk;

    // the receiver cannot stall, so every strobe is checked at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_run(o_longest_run);
    end

    // offer one item, optionally after a random pause, and hold it until accepted;
    // start is left high so back-to-back items need no second assignment in a step
    task automatic drive_item(input logic kind, input logic [ROW_W-1:0] r,
                              input logic [COL_W-1:0] c, input logic v);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_kind  <= kind;
        i_row   <= r;
        i_col   <= c;
        i_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(kind, r, c, v);
    endtask

    // stop sending and wait until every toggle has reported and the pipe is empty
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // both size registers, one write each on consecutive edges; only called when idle
    task automatic set_sizes(input logic [CFG_W-1:0] rows_v, input logic [CFG_W-1:0] cols_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ROWS;
        i_cfg_data <= rows_v;
        @(posedge i_clk);
        board.set_reg(REG_ROWS, rows_v);
        i_cfg_idx  <= REG_COLS;
        i_cfg_data <= cols_v;
        @(posedge i_clk);
        board.set_reg(REG_COLS, cols_v);
        i_cfg_we <= 1'b0;
        settings_seen++;
    endtask

    // rows cluster in a small set so runs grow long; a quarter spread over all 64
    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(0, 3) == 0) return ROW_W'($urandom_range(0, 63));
        return ROW_W'($urandom_range(0, 7));
    endfunction

    // mostly segments of ones loaded into a row so runs build up and break,
    // mixed with loose toggles and random loads
    task automatic random_items(input int n);
        int               done;
        int               mode;
        int               seg_len;
        int               seg_start;
        logic [ROW_W-1:0] r;
        logic             v;
        done = 0;
        while (done < n) begin
            mode = $urandom_range(0, 9);
            if (mode <= 4) begin
                r = pick_row();
                if ($urandom_range(0, 7) == 0) begin
                    seg_start = 0;
                    seg_len   = 64;
                end else begin
                    seg_start = $urandom_range(0, 63);
                    seg_len   = $urandom_range(1, 16);
                end
                v = ($urandom_range(0, 4) != 0);
                for (int k = 0; k < seg_len && seg_start + k < 64; k++) begin
                    drive_item(KIND_LOAD, r, COL_W'(seg_start + k), v);
                    done++;
                end
                // close most segments with a report
                if ($urandom_range(0, 2) != 0) begin
                    drive_item(KIND_TOGGLE, r, COL_W'($urandom_range(0, 63)),
                               1'($urandom_range(0, 1)));
                    done++;
                end
            end else if (mode <= 7) begin
                drive_item(KIND_TOGGLE, pick_row(), COL_W'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)));
                done++;
            end else begin
                drive_item(KIND_LOAD, ROW_W'($urandom_range(0, 63)),
                           COL_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                done++;
            end
        end
    endtask

    initial begin
        board         = new();
        idle_odds     = 4;
        settings_seen = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset sizes: corner cells, both kinds, both values
        drive_item(KIND_TOGGLE, 6'd0,  6'd0,  1'b0);   // single one, reports 1
        drive_item(KIND_TOGGLE, 6'd0,  6'd0,  1'b1);   // back to empty, reports 0
        drive_item(KIND_LOAD,   6'd63, 6'd63, 1'b1);
        drive_item(KIND_TOGGLE, 6'd63, 6'd62, 1'b0);   // run of two at the top corner
        drive_item(KIND_LOAD,   6'd63, 6'd63, 1'b0);
        drive_item(KIND_TOGGLE, 6'd63, 6'd62, 1'b1);
        drive_item(KIND_LOAD,   6'd0,  6'd63, 1'b1);
        drive_item(KIND_LOAD,   6'd0,  6'd62, 1'b1);
        drive_item(KIND_LOAD,   6'd0,  6'd61, 1'b1);
        drive_item(KIND_TOGGLE, 6'd1,  6'd0,  1'b0);   // max from another row
        drive_item(KIND_LOAD,   6'd1,  6'd1,  1'b1);
        drive_item(KIND_TOGGLE, 6'd0,  6'd62, 1'b0);   // split the run in row 0
        drive_item(KIND_LOAD,   6'd0,  6'd62, 1'b1);   // join it again
        drive_item(KIND_LOAD,   6'd0,  6'd62, 1'b1);   // rewrite of the same value
        drive_item(KIND_TOGGLE, 6'd42, 6'd21, 1'b1);
        drive_item(KIND_LOAD,   6'd42, 6'd21, 1'b0);
        drive_item(KIND_TOGGLE, 6'd63, 6'd0,  1'b1);
        drive_item(KIND_TOGGLE, 6'd21, 6'd42, 1'b0);
        drain();

        // sizes above the grid clamp to 64
        set_sizes(7'd127, 7'd127);
        random_items(150);
        drain();

        // sizes of one: only cell 0,0 is live, the rest is out of range
        set_sizes(7'd1, 7'd1);
        random_items(120);
        drain();

        // full grid, with one mid-phase pause until every report is in
        set_sizes(7'd64, 7'd64);
        idle_odds = 3;
        random_items(130);
        drain();
        idle_odds = 0;
        random_items(130);
        drain();

        // zero sizes: nothing changes, toggles report the stale maximum
        set_sizes(7'd0, 7'd0);
        idle_odds = 4;
        random_items(40);
        drain();

        // random sizes: rows kept beyond the range still count, high columns are hidden
        set_sizes(7'($urandom_range(2, 63)), 7'($urandom_range(2, 63)));
        idle_odds = 2;
        random_items(150);
        drain();

        set_sizes(7'd20, 7'd64);
        idle_odds = 5;
        random_items(150);
        drain();

        // last part without any pause
        set_sizes(7'd64, 7'($urandom_range(1, 64)));
        idle_odds = 0;
        random_items(150);
        drain();

        $display("covered %0d loads and %0d toggles over %0d size settings",
                 board.loads, board.toggles, settings_seen);
        $display("checked %0d reports, %0d still waiting, %0d mismatches",
                 board.checked, board.pending(), board.errors);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("timeout waiting on the tracker");
        $display("status: fail");
        $finish;
    end

endmodule
